// ----- rtl/core/valloc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valloc_pkg
// Shared types, sizes and microcode ROM for the oldest-steal voice allocator.
// ----------------------------------------------------------------------------
package valloc_pkg;

   // sizes
   localparam int VOICES     = 8;
   localparam int STAMP_BITS = 32;
   localparam int IDX_BITS   = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int NOTE_BITS  = 7;
   localparam int HELD_BITS  = 8;
   localparam int ACT_BITS   = 8;
   localparam int STEP_BITS  = 2;

   localparam logic [HELD_BITS-1:0]  NO_NOTE   = HELD_BITS'(128);
   localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

   // event kinds
   localparam logic FUNC_NOTE_ON  = 1'b0;
   localparam logic FUNC_NOTE_OFF = 1'b1;

   typedef logic [STEP_BITS-1:0] step_type;

   // program steps
   localparam step_type STEP_FETCH  = 2'd0;
   localparam step_type STEP_SCAN   = 2'd1;
   localparam step_type STEP_COMMIT = 2'd2;
   localparam step_type STEP_EMIT   = 2'd3;

   // jump conditions
   typedef enum logic [1:0] {
      COND_ALWAYS    = 2'd0,
      COND_ACCEPT    = 2'd1,
      COND_SCAN_DONE = 2'd2,
      COND_OUT_FREE  = 2'd3
   } cond_type;

   // one control word
   typedef struct packed {
      logic     take;     // offer ready to the request channel
      logic     scan;     // evaluate one voice and advance the index
      logic     commit;   // write the chosen voice, bump the event counter
      logic     emit;     // load the response register
      cond_type cond;
      step_type jump_true;
      step_type jump_false;
   } ucode_type;

   // request and response beats
   typedef struct packed {
      logic                 func;
      logic [NOTE_BITS-1:0] note;
      logic [ACT_BITS-1:0]  active_mask;
   } req_beat_type;

   typedef struct packed {
      logic                voice_valid;
      logic [2:0]          voice_index;
      logic                stolen;
      logic [ACT_BITS-1:0] release_mask;
   } rsp_beat_type;

   // microcode ROM
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      unique case (step)
         STEP_FETCH: begin
            w.take = 1'b1;
            w.cond = COND_ACCEPT;
            w.jump_true  = STEP_SCAN;
            w.jump_false = STEP_FETCH;
         end
         STEP_SCAN: begin
            w.scan = 1'b1;
            w.cond = COND_SCAN_DONE;
            w.jump_true  = STEP_COMMIT;
            w.jump_false = STEP_SCAN;
         end
         STEP_COMMIT: begin
            w.commit = 1'b1;
            w.cond = COND_ALWAYS;
            w.jump_true  = STEP_EMIT;
            w.jump_false = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit = 1'b1;
            w.cond = COND_OUT_FREE;
            w.jump_true  = STEP_FETCH;
            w.jump_false = STEP_EMIT;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.jump_true  = STEP_FETCH;
            w.jump_false = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/valloc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valloc_req_if
// Valid/ready channel carrying note events into the allocator.
// ----------------------------------------------------------------------------
interface valloc_req_if;
   import valloc_pkg::*;

   logic         valid;
   logic         ready;
   req_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/valloc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valloc_rsp_if
// Valid/ready channel carrying allocation results out of the allocator.
// ----------------------------------------------------------------------------
interface valloc_rsp_if;
   import valloc_pkg::*;

   logic         valid;
   logic         ready;
   rsp_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/voice_allocator_oldest_steal.sv -----
`timescale 1ns / 1ps
// Events are taken one at a time; the scan step visits one voice
//   per cycle through a single compare datapath driven by the microcode ROM.
// The response register lets the next event be taken while a result waits.
// Reset (synchronous, active high): notes to none, stamps to 0, counter to 1.
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal
// Polyphonic voice allocator: lowest free voice, else steal the oldest stamp;
// note-off returns the mask of voices holding the note.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal (
   input logic       clock,
   input logic       reset,
   valloc_req_if.sink   req_bus,
   valloc_rsp_if.source rsp_bus
);
   import valloc_pkg::*;

   localparam int PAD_BITS = VOICES + 8;

   // sequencer
   step_type  step_ff, step_in;
   ucode_type uword;
   logic      cond_true;

   // latched event
   logic                 func_ff;
   logic [NOTE_BITS-1:0] note_ff;
   logic [ACT_BITS-1:0]  active_ff;

   // scan state
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   free_ff, free_in;
   logic [IDX_BITS-1:0]   old_idx_ff, old_idx_in;
   logic [STAMP_BITS-1:0] oldest_ff, oldest_in;
   logic [VOICES-1:0]     rel_ff, rel_in;

   // voice store and counter
   logic [HELD_BITS-1:0]  held_note_ff [VOICES];
   logic [STAMP_BITS-1:0] start_stamp_ff [VOICES];
   logic [STAMP_BITS-1:0] counter_ff;

   // response register
   logic         rsp_valid_ff;
   rsp_beat_type rsp_data_ff, rsp_data_in;

   // derived
   logic [PAD_BITS-1:0]   act_pad;
   logic [VOICES-1:0]     act_ext;
   logic                  busy;
   logic [HELD_BITS-1:0]  cur_note;
   logic [STAMP_BITS-1:0] cur_stamp;
   logic                  scan_last;
   logic                  accept;
   logic                  out_free;
   logic [IDX_BITS-1:0]   pick;
   logic [IDX_BITS+2:0]   pick_pad;
   logic [PAD_BITS-1:0]   rel_pad;

   // control word fetch
   assign uword     = ucode_rom(step_ff);
   assign accept    = uword.take & req_bus.valid;
   assign out_free  = ~rsp_valid_ff | rsp_bus.ready;
   assign scan_last = (idx_ff == IDX_BITS'(VOICES - 1));

   always_comb begin
      case (uword.cond)
         COND_ALWAYS:    cond_true = 1'b1;
         COND_ACCEPT:    cond_true = accept;
         COND_SCAN_DONE: cond_true = scan_last;
         COND_OUT_FREE:  cond_true = out_free;
         default:        cond_true = 1'b1;
      endcase
      step_in = cond_true ? uword.jump_true : uword.jump_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   assign req_bus.ready = uword.take;

   // latch the event on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_bus.data.func;
         note_ff   <= req_bus.data.note;
         active_ff <= req_bus.data.active_mask;
      end
   end

   // voices past the eighth never read busy
   assign act_pad   = PAD_BITS'(active_ff);
   assign act_ext   = act_pad[VOICES-1:0];
   assign busy      = act_ext[idx_ff];
   assign cur_note  = held_note_ff[idx_ff];
   assign cur_stamp = start_stamp_ff[idx_ff];

   // scan datapath: one voice per cycle
   always_comb begin
      idx_in     = idx_ff;
      found_in   = found_ff;
      free_in    = free_ff;
      old_idx_in = old_idx_ff;
      oldest_in  = oldest_ff;
      rel_in     = rel_ff;
      if (accept) begin
         idx_in   = '0;
         found_in = 1'b0;
         rel_in   = '0;
      end else if (uword.scan) begin
         idx_in = scan_last ? '0 : idx_ff + 1'b1;
         if (!found_ff && !busy) begin
            found_in = 1'b1;
            free_in  = idx_ff;
         end
         if ((idx_ff == '0) || (cur_stamp < oldest_ff)) begin
            oldest_in  = cur_stamp;
            old_idx_in = idx_ff;
         end
         rel_in[idx_ff] = (cur_note == {1'b0, note_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
      free_ff    <= free_in;
      old_idx_ff <= old_idx_in;
      oldest_ff  <= oldest_in;
      rel_ff     <= rel_in;
   end

   assign pick = found_ff ? free_ff : old_idx_ff;

   // voice store and event counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            held_note_ff[v]   <= NO_NOTE;
            start_stamp_ff[v] <= '0;
         end
         counter_ff <= STAMP_BITS'(1);
      end else if (uword.commit) begin
         if (func_ff == FUNC_NOTE_ON) begin
            held_note_ff[pick]   <= {1'b0, note_ff};
            start_stamp_ff[pick] <= counter_ff;
         end
         if (counter_ff != STAMP_MAX) begin
            counter_ff <= counter_ff + 1'b1;
         end
      end
   end

   // response formatting
   assign pick_pad = (IDX_BITS + 3)'(pick);
   assign rel_pad  = PAD_BITS'(rel_ff);

   always_comb begin
      rsp_data_in = '0;
      if (func_ff == FUNC_NOTE_ON) begin
         rsp_data_in.voice_valid = 1'b1;
         rsp_data_in.voice_index = pick_pad[2:0];
         rsp_data_in.stolen      = ~found_ff;
      end else begin
         rsp_data_in.release_mask = rel_pad[ACT_BITS-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (uword.emit && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (uword.emit && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // checks
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (step_ff == STEP_SCAN && idx_ff == '0))
      else $error("accepted event did not start the voice scan");

   a_free_not_busy: assert property (@(posedge clock) disable iff (reset)
      (uword.commit && found_ff) |-> !act_ext[free_ff])
      else $error("free voice chosen while its active bit is set");

   a_counter_nonzero: assert property (@(posedge clock) disable iff (reset)
      counter_ff != '0)
      else $error("event counter reached zero");

   a_counter_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (counter_ff >= $past(counter_ff)))
      else $error("event counter went backwards");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.voice_valid && rsp_data_ff.release_mask != '0))
      else $error("response carries both a voice and a release mask");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the oldest-steal voice allocator. A voice book
// class mirrors held notes, start stamps and the event counter, predicts
// the grant or release mask of every accepted note event and compares each
// response beat with the oldest prediction. Directed events cover the
// reset ties, empty voices, full and empty masks and shared notes. A random
// run follows, with idle bursts on both channels and a quiet tail.
// ----------------------------------------------------------------------------
module tb;
   import valloc_pkg::*;

   // mirror of the allocator plus the queue of results still owed
   class voice_book;
      logic [HELD_BITS-1:0]  held [VOICES];
      logic [STAMP_BITS-1:0] stamp [VOICES];
      logic [STAMP_BITS-1:0] counter;
      rsp_beat_type          due [$];
      int                    errors;

      function new();
         for (int v = 0; v < VOICES; v++) begin
            held[v]  = NO_NOTE;
            stamp[v] = '0;
         end
         counter = 1;
         errors  = 0;
      endfunction

      function int waiting();
         return due.size();
      endfunction

      // note an accepted event and work out its result
      function void take_event(req_beat_type ev);
         rsp_beat_type grant;
         int           pick;
         bit           found;
         grant = '0;
         if (ev.func == FUNC_NOTE_ON) begin
            found = 1'b0;
            pick  = 0;
            // lowest voice that is not sounding
            for (int v = 0; v < VOICES; v++) begin
               if (!found && (v >= ACT_BITS || !ev.active_mask[v])) begin
                  pick  = v;
                  found = 1'b1;
               end
            end
            // all busy: oldest stamp, strict compare keeps the lower index
            if (!found) begin
               pick = 0;
               for (int v = 1; v < VOICES; v++)
                  if (stamp[v] < stamp[pick]) pick = v;
            end
            held[pick]        = {1'b0, ev.note};
            stamp[pick]       = counter;
            grant.voice_valid = 1'b1;
            grant.voice_index = 3'(pick);
            grant.stolen      = !found;
         end else begin
            for (int v = 0; v < VOICES && v < ACT_BITS; v++)
               if (held[v] == {1'b0, ev.note}) grant.release_mask[v] = 1'b1;
         end
         // saturating event count
         if (counter != STAMP_MAX) counter = counter + 1'b1;
         due.insert(due.size(), grant);
      endfunction

      // compare one response beat with the oldest prediction
      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (due.size() == 0) begin
            $display("%0t: response with none owed, actual %h", $time, got);
            errors++;
            return;
         end
         want = due.pop_front();
         if (got.voice_valid !== want.voice_valid) begin
            $display("%0t: voice_valid expected %0d actual %0d",
                     $time, want.voice_valid, got.voice_valid);
            errors++;
         end
         if (got.voice_index !== want.voice_index) begin
            $display("%0t: voice_index expected %0d actual %0d",
                     $time, want.voice_index, got.voice_index);
            errors++;
         end
         if (got.stolen !== want.stolen) begin
            $display("%0t: stolen expected %0d actual %0d",
                     $time, want.stolen, got.stolen);
            errors++;
         end
         if (got.release_mask !== want.release_mask) begin
            $display("%0t: release_mask expected %h actual %h",
                     $time, want.release_mask, got.release_mask);
            errors++;
         end
      endfunction
   endclass

   localparam int LATENCY     = VOICES + 3;
   localparam int RAND_EVENTS = 1030;
   localparam int CALM_TAIL   = 200;

   logic clock = 1'b0;
   logic reset;
   bit   calm = 1'b0;   // no idling on either side once set

   valloc_req_if req_if ();
   valloc_rsp_if rsp_if ();

   voice_book book = new();

   voice_allocator_oldest_steal uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // one note event; valid stays high into the next event unless a gap is drawn
   task automatic send_event(input logic func, input logic [NOTE_BITS-1:0] note,
                             input logic [ACT_BITS-1:0] mask, input bit may_idle);
      int gap;
      if (may_idle && !calm && $urandom_range(3) == 0) begin
         gap = $urandom_range(16, 1);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= '{func: func, note: note, active_mask: mask};
      do @(posedge clock); while (!req_if.ready);
      book.take_event(req_if.data);
   endtask

   // sounding-voice patterns, weighted toward full masks so stealing is common
   function automatic logic [ACT_BITS-1:0] pick_mask();
      case ($urandom_range(5))
         0, 1:    return '1;
         2:       return ~(ACT_BITS'(1) << $urandom_range(ACT_BITS - 1));
         3:       return ACT_BITS'($urandom_range(255));
         4:       return '0;
         default: return ACT_BITS'($urandom_range(255) | $urandom_range(255));
      endcase
   endfunction

   // note-offs mostly name a note that some voice holds
   function automatic logic [NOTE_BITS-1:0] pick_off_note();
      logic [HELD_BITS-1:0] h;
      h = book.held[$urandom_range(VOICES - 1)];
      if (h != NO_NOTE && $urandom_range(9) < 7) return h[NOTE_BITS-1:0];
      return NOTE_BITS'($urandom_range(127));
   endfunction

   // response side: check beats, then draw the next ready
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) book.check_result(rsp_if.data);
         if (calm) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(4) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(16, 1) - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // request side
   initial begin
      bit may_idle;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty voices, reset-stamp ties, mask extremes, shared notes
      send_event(FUNC_NOTE_OFF, 7'd0, 8'h00, 1'b1);
      send_event(FUNC_NOTE_ON, 7'd60, 8'hFF, 1'b1);
      send_event(FUNC_NOTE_ON, 7'd60, 8'hFF, 1'b1);
      send_event(FUNC_NOTE_ON, 7'd127, 8'h00, 1'b1);
      send_event(FUNC_NOTE_ON, 7'd0, 8'h7F, 1'b1);
      send_event(FUNC_NOTE_ON, 7'd60, 8'hFE, 1'b1);
      send_event(FUNC_NOTE_OFF, 7'd60, 8'hFF, 1'b1);
      send_event(FUNC_NOTE_OFF, 7'd127, 8'h55, 1'b1);
      send_event(FUNC_NOTE_OFF, 7'd0, 8'hAA, 1'b1);
      for (int v = 0; v < VOICES; v++)
         send_event(FUNC_NOTE_ON, 7'd64, ~(ACT_BITS'(1) << v), 1'b1);
      send_event(FUNC_NOTE_OFF, 7'd64, 8'h00, 1'b1);
      send_event(FUNC_NOTE_ON, 7'd1, 8'hFF, 1'b1);
      send_event(FUNC_NOTE_ON, 7'd2, 8'h80, 1'b1);
      send_event(FUNC_NOTE_ON, 7'd3, 8'h01, 1'b1);

      // random: played-style events with idle stretches, then a quiet tail
      for (int i = 0; i < RAND_EVENTS; i++) begin
         if (i == RAND_EVENTS / 2) begin
            // hold off until the allocator has drained
            req_if.valid <= 1'b0;
            while (book.waiting() != 0) @(posedge clock);
            @(posedge clock);
         end
         if (i == RAND_EVENTS - CALM_TAIL) calm = 1'b1;
         may_idle = (i % 150) < 110;
         if ($urandom_range(2) == 0)
            send_event(FUNC_NOTE_OFF, pick_off_note(), pick_mask(), may_idle);
         else if ($urandom_range(1) == 0)
            send_event(FUNC_NOTE_ON, NOTE_BITS'($urandom_range(72, 48)), pick_mask(),
                       may_idle);
         else
            send_event(FUNC_NOTE_ON, NOTE_BITS'($urandom_range(127)), pick_mask(),
                       may_idle);
      end
      req_if.valid <= 1'b0;

      // drain, then give a stray beat time to show up
      while (book.waiting() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (book.errors == 0 && book.waiting() == 0) begin
         $display("PASS voice_allocator_oldest_steal");
      end else begin
         $display("FAIL voice_allocator_oldest_steal");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("FAIL voice_allocator_oldest_steal");
      $finish;
   end

endmodule
